### rtl/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types, codes and the reciprocal table for the 3x3 box blur.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bb3_pkg;

  localparam int unsigned FW_W  = 11;
  localparam int unsigned FH_W  = 13;
  localparam int unsigned CFG_W = 13;

  localparam logic [15:0] FW_RESET = 16'd640;
  localparam logic [15:0] FH_RESET = 16'd480;

  // register indexes
  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  // command codes
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam int unsigned RECIP_SHIFT = 16;

  typedef struct packed {
    logic       command;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_last;
  } pix_out_t;

  // classified item passed from front to back (line buffer address rides alongside)
  typedef struct packed {
    logic        started;
    logic [2:0]  row_mask;
    logic [2:0]  col_mask;
    logic        last;
    logic [23:0] pix;
  } bb3_item_t;

  // ceil(2^16 / n): exact floor division for numerators below 8192
  function automatic logic [16:0] bb3_recip(input logic [3:0] n);
    logic [16:0] m;
    case (n)
      4'd2:    m = 17'd32768;
      4'd3:    m = 17'd21846;
      4'd4:    m = 17'd16384;
      4'd5:    m = 17'd13108;
      4'd6:    m = 17'd10923;
      4'd7:    m = 17'd9363;
      4'd8:    m = 17'd8192;
      4'd9:    m = 17'd7282;
      default: m = 17'd65536;
    endcase
    return m;
  endfunction

endpackage

### rtl/box_blur_3x3_edge_aware_top.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware_top
// 3x3 box blur of an RGB888 raster stream; borders average in-image pixels.
//
// Sustains one item per clock unless the output stalls: the line buffer is a
// single memory with one read and one write port, read when an item enters
// the datapath and written back when it retires, with a bypass for back-to-back
// use of one column. A result is registered through the queue and the read,
// sum and divide stages after the item that releases it is accepted; that item
// is the input one row plus one pixel later. Drain commands flush the tail.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module box_blur_3x3_edge_aware_top import bb3_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pix_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output pix_out_t         out_data_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned DW = CW + $bits(bb3_item_t);

  logic          q_full, push, q_valid, pop;
  logic [CW-1:0] push_addr;
  bb3_item_t     push_item;
  logic [DW-1:0] q_data;

  bb3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_addr_o (push_addr),
    .push_item_o (push_item)
  );

  bb3_queue #(.DW(DW)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_addr, push_item}),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  bb3_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_addr_i    (q_data[DW-1:DW-CW]),
    .q_item_i    (bb3_item_t'(q_data[DW-CW-1:0])),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### rtl/bb3_front.sv
// ----------------------------------------------------------------------------
// bb3_front
// Config registers, raster position tracking and item classification.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bb3_front import bb3_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024,
  localparam int unsigned CW = $clog2(MAX_WIDTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pix_in_t          in_data_i,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             q_full_i,
  output logic             push_o,
  output logic [CW-1:0]    push_addr_o,
  output bb3_item_t        push_item_o
);

  logic [FW_W-1:0] fw_q;
  logic [FH_W-1:0] fh_q;
  logic [CW:0]     w_eff;
  logic [FH_W-1:0] h_eff;

  logic [CW-1:0]   in_col_q, out_col_q;
  logic [FH_W:0]   in_row_q;
  logic [FH_W-1:0] out_row_q;

  logic            accept, done, started, last, wrap, owrap;
  logic [CW:0]     col_inc, ocol_inc;

  always_comb begin
    if (fw_q == '0) begin
      w_eff = (CW+1)'(1);
    end else if (32'(fw_q) > 32'(MAX_WIDTH)) begin
      w_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW+1)'(fw_q);
    end
    h_eff = (fh_q == '0) ? FH_W'(1) : fh_q;
  end

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign done       = in_row_q >= (FH_W+1)'(h_eff);
  // once the frame's pixels are in, every item (pixel or not) is a flush step
  assign push_o     = accept && (done || in_data_i.command == CMD_PIXEL);

  assign col_inc  = {1'b0, in_col_q} + (CW+1)'(1);
  assign wrap     = col_inc >= w_eff;
  assign ocol_inc = {1'b0, out_col_q} + (CW+1)'(1);
  assign owrap    = ocol_inc >= w_eff;
  assign started  = (in_row_q > (FH_W+1)'(1)) ||
                    (in_row_q == (FH_W+1)'(1) && in_col_q != '0);
  assign last     = (out_row_q == h_eff - FH_W'(1)) &&
                    ({1'b0, out_col_q} == w_eff - (CW+1)'(1));

  always_comb begin
    push_addr_o          = in_col_q;
    push_item_o.started  = started;
    push_item_o.last     = last;
    push_item_o.row_mask = {({1'b0, out_row_q} + (FH_W+1)'(1)) < (FH_W+1)'(h_eff),
                            out_row_q < h_eff,
                            out_row_q != '0};
    push_item_o.col_mask = {ocol_inc < w_eff,
                            {1'b0, out_col_q} < w_eff,
                            out_col_q != '0};
    push_item_o.pix      = done ? 24'd0
                                : {in_data_i.red_in, in_data_i.green_in, in_data_i.blue_in};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q      <= FW_W'(FW_RESET);
      fh_q      <= FH_W'(FH_RESET);
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH:  fw_q <= cfg_data_i[FW_W-1:0];
        CFG_FRAME_HEIGHT: fh_q <= cfg_data_i[FH_W-1:0];
        default: ;
      endcase
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (push_o) begin
      if (started && last) begin
        in_col_q  <= '0;
        in_row_q  <= '0;
        out_col_q <= '0;
        out_row_q <= '0;
      end else begin
        if (wrap) begin
          in_col_q <= '0;
          in_row_q <= in_row_q + (FH_W+1)'(1);
        end else begin
          in_col_q <= col_inc[CW-1:0];
        end
        if (started) begin
          if (owrap) begin
            out_col_q <= '0;
            out_row_q <= out_row_q + FH_W'(1);
          end else begin
            out_col_q <= ocol_inc[CW-1:0];
          end
        end
      end
    end
  end

endmodule

### rtl/bb3_queue.sv
// ----------------------------------------------------------------------------
// bb3_queue
// Two-entry queue decoupling the classifier from the filter datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bb3_queue #(
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output logic [DW-1:0] data_o
);

  logic [DW-1:0] mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

### rtl/bb3_back.sv
// ----------------------------------------------------------------------------
// bb3_back
// Line buffer, 3x3 window, masked sums and rounded divide by neighbor count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bb3_back import bb3_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024,
  localparam int unsigned CW = $clog2(MAX_WIDTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  logic [CW-1:0] q_addr_i,
  input  bb3_item_t     q_item_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output pix_out_t      out_data_o
);

  // line buffer: entry holds {upper row, middle row} of one column
  logic [47:0]   lbuf [MAX_WIDTH];
  logic [47:0]   rdata_q, fwd_data_q, cur, wdata;
  logic          fwd_q;

  logic          s1_valid_q, s1_fire, s1_ready;
  bb3_item_t     s1_q;
  logic [CW-1:0] s1_addr_q;

  logic [23:0]   win_q [9];
  logic [23:0]   win_d [9];
  logic [23:0]   col [3];

  logic          s2_valid_q, s2_ready;
  logic [11:0]   s2_sum_q [3];
  logic [11:0]   sum_d [3];
  logic [3:0]    s2_n_q, n_d;
  logic          s2_last_q;

  logic          s3_ready;
  logic [28:0]   prod [3];
  logic [16:0]   recip;
  logic [11:0]   half;

  assign s3_ready = !out_valid_o || !out_stall_i;
  assign s2_ready = !s2_valid_q || s3_ready;
  assign s1_fire  = s1_valid_q && (!s1_q.started || s2_ready);
  assign s1_ready = !s1_valid_q || s1_fire;
  assign pop_o    = q_valid_i && s1_ready;

  assign cur   = fwd_q ? fwd_data_q : rdata_q;
  assign wdata = {cur[23:0], s1_q.pix};

  // read on load into stage 1, read-modify-write when stage 1 retires
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      lbuf[s1_addr_q] <= wdata;
    end
    if (pop_o) begin
      rdata_q    <= lbuf[q_addr_i];
      fwd_data_q <= wdata;
      s1_q       <= q_item_i;
      s1_addr_q  <= q_addr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= pop_o;
        fwd_q      <= pop_o && s1_fire && (s1_addr_q == q_addr_i);
      end
    end
  end

  always_comb begin
    logic [1:0] rc, cc;
    col[0] = cur[47:24];
    col[1] = cur[23:0];
    col[2] = s1_q.pix;
    for (int r = 0; r < 3; r++) begin
      win_d[r*3]   = win_q[r*3+1];
      win_d[r*3+1] = win_q[r*3+2];
      win_d[r*3+2] = col[r];
    end
    for (int ch = 0; ch < 3; ch++) begin
      sum_d[ch] = '0;
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (s1_q.row_mask[r] && s1_q.col_mask[c]) begin
          sum_d[0] = sum_d[0] + 12'(win_d[r*3+c][23:16]);
          sum_d[1] = sum_d[1] + 12'(win_d[r*3+c][15:8]);
          sum_d[2] = sum_d[2] + 12'(win_d[r*3+c][7:0]);
        end
      end
    end
    rc  = 2'($countones(s1_q.row_mask));
    cc  = 2'($countones(s1_q.col_mask));
    n_d = 4'(rc) * 4'(cc);
    if (n_d == '0) begin
      n_d = 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_fire) begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_q.started && s2_ready) begin
      s2_sum_q  <= sum_d;
      s2_n_q    <= n_d;
      s2_last_q <= s1_q.last;
    end
  end

  always_comb begin
    recip = bb3_recip(s2_n_q);
    half  = 12'(s2_n_q >> 1);
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = 29'(s2_sum_q[ch] + half) * 29'(recip);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_valid_q <= s1_fire && s1_q.started;
      end
      if (s3_ready) begin
        out_valid_o <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && s2_valid_q) begin
      out_data_o.red_out    <= prod[0][RECIP_SHIFT+7:RECIP_SHIFT];
      out_data_o.green_out  <= prod[1][RECIP_SHIFT+7:RECIP_SHIFT];
      out_data_o.blue_out   <= prod[2][RECIP_SHIFT+7:RECIP_SHIFT];
      out_data_o.frame_last <= s2_last_q;
    end
  end

  a_no_lost_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_fire && s1_q.started && !s2_ready))
    else $error("stage 1 retired a result while stage 2 was blocked");
  a_pop_needs_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> q_valid_i)
    else $error("pop from empty queue");
  a_fwd_has_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> s1_valid_q)
    else $error("bypass flag set without an item in stage 1");
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> (s2_n_q != 4'd0 && s2_n_q <= 4'd9))
    else $error("neighbor count out of range");

endmodule
